// ===== rtl/assert_macros.svh =====
// Assertion macros used by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Invariant checked at every clock edge outside reset.
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== rtl/ptrt_pkg.sv =====
package ptrt_pkg;

  localparam int PEND_DEPTH = 1024;
  localparam int PEND_AW    = $clog2(PEND_DEPTH);
  localparam int PCNT_W     = $clog2(PEND_DEPTH + 1);
  localparam int MAX_OUT    = 8;
  localparam int OUT_IW     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int OCNT_W     = $clog2(MAX_OUT + 1);

  localparam logic [1:0] ACT_ENQ   = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_REPLY = 2'd3;

  localparam logic [1:0] KIND_PROBE   = 2'd0;
  localparam logic [1:0] KIND_LATENCY = 2'd1;
  localparam logic [1:0] KIND_IDLE    = 2'd2;

  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_RETRY    = 2'd1;
  localparam logic [1:0] REG_PARALLEL = 2'd2;

  localparam logic [15:0] TIMEOUT_RST  = 16'd5000;
  localparam logic [2:0]  RETRY_RST    = 3'd2;
  localparam logic [3:0]  PARALLEL_RST = 4'd8;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  target;
    logic [15:0] reply_sequence;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  probe_target;
    logic [15:0] probe_sequence;
    logic [2:0]  attempt;
    logic [31:0] latency_ticks;
    logic        last;
  } result_t;

endpackage

// ===== rtl/ptrt_ram.sv =====
module ptrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/probe_timeout_retry_tracker_unit.sv =====
// Probe tracker with timeout and retry.
// Command channel: an item is taken when start is high and busy is low.
// Actions: enqueue a target, start a run, one millisecond tick, or a reply.
// Results come out at most one per cycle on result, marked by result_valid;
// the final result of an item carries last. Each result is held back until
// the next one is formed or the item ends, so the last one shows in the
// cycle in which busy falls. The receiver cannot stall, so every strobed
// result is consumed in its cycle. After an item is taken, an enqueue, an
// ignored start, a tick while stopped or an unmatched reply passes only
// through S_EXEC and S_FINISH. Other items also pass through S_SCAN, once
// per timed-out probe and once more, then S_FILL_RD, plus an S_FILL_WR and
// S_FILL_RD pair per pending target issued (one read of the RAM, one append).
// The pending FIFO is a 1024-entry RAM with a registered read port; up to
// eight outstanding probes sit in a short shift list in flip-flops.
// Configuration goes through the APB port: timeout_ticks at 0x0,
// retry_limit at 0x4, parallel_limit at 0x8; write only while not busy.
// Reset restores the register defaults, empties both queues, stops the
// run and clears the millisecond counter and the sequence counter.
`include "assert_macros.svh"

module probe_timeout_retry_tracker_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  ptrt_pkg::item_t          item,
  output logic                     result_valid,
  output ptrt_pkg::result_t        result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_FILL_RD, S_FILL_WR, S_FINISH
  } state_t;

  state_t state;
  ptrt_pkg::item_t cur;

  logic [15:0] timeout_ticks;
  logic [2:0]  retry_limit;
  logic [3:0]  parallel_limit;

  logic [ptrt_pkg::PEND_AW-1:0] pend_head;
  logic [ptrt_pkg::PCNT_W-1:0]  pend_count;
  logic [9:0]  out_tgt   [ptrt_pkg::MAX_OUT];
  logic [15:0] out_seq   [ptrt_pkg::MAX_OUT];
  logic [31:0] out_stamp [ptrt_pkg::MAX_OUT];
  logic [2:0]  out_try   [ptrt_pkg::MAX_OUT];
  logic [ptrt_pkg::OCNT_W-1:0] out_count;
  logic [15:0] next_seq;
  logic        running;
  logic [31:0] now_ms;

  ptrt_pkg::result_t held;
  logic              held_valid;

  logic        gen_valid;
  ptrt_pkg::result_t gen;

  logic                         ram_we;
  logic [ptrt_pkg::PEND_AW-1:0] ram_waddr;
  logic [ptrt_pkg::PEND_AW:0]   wsum;
  logic [9:0]                   ram_rdata;

  logic [31:0] tmo;
  logic [ptrt_pkg::OCNT_W-1:0] lim;
  logic [31:0] age0;
  logic        timed_out;
  logic        hit;
  logic [ptrt_pkg::OUT_IW-1:0] hit_idx;
  logic        cfg_wr;

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      ptrt_pkg::REG_TIMEOUT:  prdata = {16'd0, timeout_ticks};
      ptrt_pkg::REG_RETRY:    prdata = {29'd0, retry_limit};
      ptrt_pkg::REG_PARALLEL: prdata = {28'd0, parallel_limit};
      default:                prdata = 32'd0;
    endcase
  end

  assign tmo = (timeout_ticks == 16'd0) ? 32'd1 : {16'd0, timeout_ticks};

  always_comb begin
    if (parallel_limit == 4'd0) begin
      lim = ptrt_pkg::OCNT_W'(1);
    end else if (32'(parallel_limit) > ptrt_pkg::MAX_OUT) begin
      lim = ptrt_pkg::OCNT_W'(ptrt_pkg::MAX_OUT);
    end else begin
      lim = ptrt_pkg::OCNT_W'(parallel_limit);
    end
  end

  assign age0      = now_ms - out_stamp[0];
  assign timed_out = (out_count != '0) && (age0 >= tmo);

  // Oldest matching outstanding probe wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ptrt_pkg::MAX_OUT - 1; i >= 0; i--) begin
      if ((ptrt_pkg::OCNT_W'(i) < out_count) && (out_seq[i] == cur.reply_sequence)) begin
        hit     = 1'b1;
        hit_idx = ptrt_pkg::OUT_IW'(i);
      end
    end
  end

  // Pending FIFO write position, wrapped with one compare and subtract.
  assign wsum = (ptrt_pkg::PEND_AW + 1)'(pend_head) +
                (ptrt_pkg::PEND_AW + 1)'(pend_count);
  assign ram_waddr = (wsum >= (ptrt_pkg::PEND_AW + 1)'(ptrt_pkg::PEND_DEPTH)) ?
                     ptrt_pkg::PEND_AW'(wsum - (ptrt_pkg::PEND_AW + 1)'(ptrt_pkg::PEND_DEPTH)) :
                     ptrt_pkg::PEND_AW'(wsum);
  assign ram_we = (state == S_EXEC) && (cur.action == ptrt_pkg::ACT_ENQ) &&
                  (pend_count < ptrt_pkg::PCNT_W'(ptrt_pkg::PEND_DEPTH));

  ptrt_ram #(.WIDTH(10), .DEPTH(ptrt_pkg::PEND_DEPTH)) u_pend_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur.target),
    .raddr (pend_head),
    .rdata (ram_rdata)
  );

  // Result produced this cycle, if any.
  always_comb begin
    gen_valid = 1'b0;
    gen       = '0;
    case (state)
      S_EXEC: begin
        if (cur.action == ptrt_pkg::ACT_REPLY && hit) begin
          gen_valid          = 1'b1;
          gen.kind           = ptrt_pkg::KIND_LATENCY;
          gen.probe_target   = out_tgt[hit_idx];
          gen.probe_sequence = cur.reply_sequence;
          gen.attempt        = out_try[hit_idx];
          gen.latency_ticks  = now_ms - out_stamp[hit_idx];
        end
      end
      S_SCAN: begin
        if (timed_out && (out_try[0] < retry_limit)) begin
          gen_valid          = 1'b1;
          gen.kind           = ptrt_pkg::KIND_PROBE;
          gen.probe_target   = out_tgt[0];
          gen.probe_sequence = next_seq;
          gen.attempt        = out_try[0] + 3'd1;
        end
      end
      S_FILL_RD: begin
        if (!((out_count < lim) && (pend_count != '0)) && (out_count == '0)) begin
          gen_valid = 1'b1;
          gen.kind  = ptrt_pkg::KIND_IDLE;
        end
      end
      S_FILL_WR: begin
        gen_valid          = 1'b1;
        gen.kind           = ptrt_pkg::KIND_PROBE;
        gen.probe_target   = ram_rdata;
        gen.probe_sequence = next_seq;
      end
      default: begin
        gen_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      timeout_ticks  <= ptrt_pkg::TIMEOUT_RST;
      retry_limit    <= ptrt_pkg::RETRY_RST;
      parallel_limit <= ptrt_pkg::PARALLEL_RST;
      pend_head      <= '0;
      pend_count     <= '0;
      out_count      <= '0;
      next_seq       <= '0;
      running        <= 1'b0;
      now_ms         <= '0;
      held_valid     <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= 1'b0;

      if (cfg_wr) begin
        case (paddr[3:2])
          ptrt_pkg::REG_TIMEOUT:  timeout_ticks  <= pwdata[15:0];
          ptrt_pkg::REG_RETRY:    retry_limit    <= pwdata[2:0];
          ptrt_pkg::REG_PARALLEL: parallel_limit <= pwdata[3:0];
          default: ;
        endcase
      end

      // One result is held back so that last can be set on the final one.
      if (gen_valid) begin
        if (held_valid) begin
          result       <= held;
          result_valid <= 1'b1;
        end
        held       <= gen;
        held_valid <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            cur   <= item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_FINISH;
          case (cur.action)
            ptrt_pkg::ACT_ENQ: begin
              if (ram_we) begin
                pend_count <= pend_count + 1'b1;
              end
            end
            ptrt_pkg::ACT_START: begin
              if (!running) begin
                running  <= 1'b1;
                next_seq <= '0;
                state    <= S_SCAN;
              end
            end
            ptrt_pkg::ACT_TICK: begin
              now_ms <= now_ms + 32'd1;
              if (running) begin
                state <= S_SCAN;
              end
            end
            default: begin
              if (hit) begin
                for (int j = 0; j < ptrt_pkg::MAX_OUT - 1; j++) begin
                  if (ptrt_pkg::OUT_IW'(j) >= hit_idx) begin
                    out_tgt[j]   <= out_tgt[j+1];
                    out_seq[j]   <= out_seq[j+1];
                    out_stamp[j] <= out_stamp[j+1];
                    out_try[j]   <= out_try[j+1];
                  end
                end
                out_count <= out_count - 1'b1;
                if (running) begin
                  state <= S_SCAN;
                end
              end
            end
          endcase
        end
        S_SCAN: begin
          if (timed_out) begin
            for (int j = 0; j < ptrt_pkg::MAX_OUT - 1; j++) begin
              out_tgt[j]   <= out_tgt[j+1];
              out_seq[j]   <= out_seq[j+1];
              out_stamp[j] <= out_stamp[j+1];
              out_try[j]   <= out_try[j+1];
            end
            if (out_try[0] < retry_limit) begin
              // The re-sent probe takes the slot freed at the tail.
              out_tgt[ptrt_pkg::OUT_IW'(out_count - 1'b1)]   <= out_tgt[0];
              out_seq[ptrt_pkg::OUT_IW'(out_count - 1'b1)]   <= next_seq;
              out_stamp[ptrt_pkg::OUT_IW'(out_count - 1'b1)] <= now_ms;
              out_try[ptrt_pkg::OUT_IW'(out_count - 1'b1)]   <= out_try[0] + 3'd1;
              next_seq <= next_seq + 16'd1;
            end else begin
              out_count <= out_count - 1'b1;
            end
          end else begin
            state <= S_FILL_RD;
          end
        end
        S_FILL_RD: begin
          if ((out_count < lim) && (pend_count != '0)) begin
            state <= S_FILL_WR;
          end else begin
            if (out_count == '0) begin
              pend_head  <= '0;
              pend_count <= '0;
              running    <= 1'b0;
            end
            state <= S_FINISH;
          end
        end
        S_FILL_WR: begin
          out_tgt[ptrt_pkg::OUT_IW'(out_count)]   <= ram_rdata;
          out_seq[ptrt_pkg::OUT_IW'(out_count)]   <= next_seq;
          out_stamp[ptrt_pkg::OUT_IW'(out_count)] <= now_ms;
          out_try[ptrt_pkg::OUT_IW'(out_count)]   <= 3'd0;
          out_count  <= out_count + 1'b1;
          next_seq   <= next_seq + 16'd1;
          pend_count <= pend_count - 1'b1;
          if (32'(pend_head) == ptrt_pkg::PEND_DEPTH - 1) begin
            pend_head <= '0;
          end else begin
            pend_head <= pend_head + 1'b1;
          end
          state <= S_FILL_RD;
        end
        S_FINISH: begin
          if (held_valid) begin
            result       <= held;
            result.last  <= 1'b1;
            result_valid <= 1'b1;
            held_valid   <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CHK_ALWAYS(a_out_bound, out_count <= ptrt_pkg::OCNT_W'(ptrt_pkg::MAX_OUT), "outstanding overflow")
  `CHK_ALWAYS(a_pend_bound, pend_count <= ptrt_pkg::PCNT_W'(ptrt_pkg::PEND_DEPTH), "pending overflow")
  `CHK_IMPLY(a_stop_empty, !running, out_count == '0, "probes outstanding while stopped")
  `CHK_IMPLY(a_idle_flushed, state == S_IDLE, !held_valid, "result left behind at end of item")

endmodule

// ===== test/probe_timeout_retry_tracker_unit_tb.sv =====
module probe_timeout_retry_tracker_unit_tb;

  typedef struct {
    bit              is_cfg;
    logic [1:0]      reg_idx;
    logic [31:0]     value;
    int              gap;
    ptrt_pkg::item_t cmd;
  } step_t;

  typedef enum logic [2:0] {
    DRV_NEXT, DRV_GAP, DRV_ISSUE, DRV_DRAIN, DRV_SETUP, DRV_ACCESS
  } drv_state_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  ptrt_pkg::item_t   item;
  logic              result_valid;
  ptrt_pkg::result_t result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  probe_timeout_retry_tracker_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  step_t             step_q[$];
  ptrt_pkg::result_t probe_events_q[$];
  ptrt_pkg::result_t batch_q[$];
  step_t             cur;
  drv_state_t        drv_st;
  int                gap_cnt;
  int                settle_cnt;
  int                mismatches;
  int                cfg_errors;
  int                accepted_items;
  int                checked_results;
  int                cfg_writes;
  longint            cycle_cnt;

  // Shadow of the tracker state.
  logic [9:0]  pend_mem [ptrt_pkg::PEND_DEPTH];
  int unsigned pend_head;
  int unsigned pend_cnt;
  logic [9:0]  out_tgt   [ptrt_pkg::MAX_OUT];
  logic [15:0] out_seq   [ptrt_pkg::MAX_OUT];
  logic [31:0] out_stamp [ptrt_pkg::MAX_OUT];
  logic [2:0]  out_tries [ptrt_pkg::MAX_OUT];
  int          out_cnt;
  logic [15:0] seq_ctr;
  bit          run_on;
  logic [31:0] now_ms;
  logic [15:0] tmo_reg;
  logic [2:0]  retry_reg;
  logic [3:0]  par_reg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic emit(logic [1:0] k, logic [9:0] t, logic [15:0] s, logic [2:0] a,
                      logic [31:0] lat);
    ptrt_pkg::result_t r;
    r.kind = k;
    r.probe_target = t;
    r.probe_sequence = s;
    r.attempt = a;
    r.latency_ticks = lat;
    r.last = 1'b0;
    batch_q.push_back(r);
  endtask

  task automatic drop_probe(int idx);
    for (int j = idx; j + 1 < out_cnt; j++) begin
      out_tgt[j] = out_tgt[j + 1];
      out_seq[j] = out_seq[j + 1];
      out_stamp[j] = out_stamp[j + 1];
      out_tries[j] = out_tries[j + 1];
    end
    if (out_cnt > 0) out_cnt--;
  endtask

  task automatic send_probe(logic [9:0] t, logic [2:0] tries);
    logic [15:0] s;
    s = seq_ctr;
    seq_ctr = seq_ctr + 16'd1;
    if (out_cnt < ptrt_pkg::MAX_OUT) begin
      out_tgt[out_cnt] = t;
      out_seq[out_cnt] = s;
      out_stamp[out_cnt] = now_ms;
      out_tries[out_cnt] = tries;
      out_cnt++;
    end
    emit(ptrt_pkg::KIND_PROBE, t, s, tries, 32'd0);
  endtask

  task automatic retire_and_refill();
    logic [31:0] tmo;
    int          lim;
    logic [9:0]  t;
    logic [2:0]  tries;
    logic [31:0] age;
    tmo = (tmo_reg == 16'd0) ? 32'd1 : {16'd0, tmo_reg};
    lim = (par_reg == 4'd0) ? 1 :
          ((par_reg > ptrt_pkg::MAX_OUT) ? ptrt_pkg::MAX_OUT : int'(par_reg));
    while (out_cnt > 0) begin
      age = now_ms - out_stamp[0];
      if (age < tmo) break;
      t = out_tgt[0];
      tries = out_tries[0];
      drop_probe(0);
      if (tries < retry_reg) send_probe(t, tries + 3'd1);
    end
    while (out_cnt < lim && pend_cnt > 0) begin
      t = pend_mem[pend_head];
      pend_head = (pend_head + 1) % ptrt_pkg::PEND_DEPTH;
      pend_cnt--;
      send_probe(t, 3'd0);
    end
    if (out_cnt == 0) begin
      pend_head = 0;
      pend_cnt = 0;
      run_on = 1'b0;
      emit(ptrt_pkg::KIND_IDLE, 10'd0, 16'd0, 3'd0, 32'd0);
    end
  endtask

  task automatic predict_events(ptrt_pkg::item_t c);
    batch_q.delete();
    case (c.action)
      ptrt_pkg::ACT_ENQ: begin
        if (pend_cnt < ptrt_pkg::PEND_DEPTH) begin
          pend_mem[(pend_head + pend_cnt) % ptrt_pkg::PEND_DEPTH] = c.target;
          pend_cnt++;
        end
      end
      ptrt_pkg::ACT_START: begin
        if (!run_on) begin
          run_on = 1'b1;
          seq_ctr = 16'd0;
          retire_and_refill();
        end
      end
      ptrt_pkg::ACT_TICK: begin
        now_ms = now_ms + 32'd1;
        if (run_on) retire_and_refill();
      end
      default: begin
        for (int i = 0; i < out_cnt; i++) begin
          if (out_seq[i] == c.reply_sequence) begin
            emit(ptrt_pkg::KIND_LATENCY, out_tgt[i], c.reply_sequence, out_tries[i],
                 now_ms - out_stamp[i]);
            drop_probe(i);
            if (run_on) retire_and_refill();
            break;
          end
        end
      end
    endcase
    if (batch_q.size() > 0) batch_q[batch_q.size() - 1].last = 1'b1;
    foreach (batch_q[i]) probe_events_q.push_back(batch_q[i]);
  endtask

  task automatic apply_reg(logic [1:0] idx, logic [31:0] v);
    case (idx)
      ptrt_pkg::REG_TIMEOUT:  tmo_reg = v[15:0];
      ptrt_pkg::REG_RETRY:    retry_reg = v[2:0];
      ptrt_pkg::REG_PARALLEL: par_reg = v[3:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    logic [31:0] v;
    case (idx)
      ptrt_pkg::REG_TIMEOUT:  v = {16'd0, tmo_reg};
      ptrt_pkg::REG_RETRY:    v = {29'd0, retry_reg};
      ptrt_pkg::REG_PARALLEL: v = {28'd0, par_reg};
      default:                v = 32'd0;
    endcase
    return v;
  endfunction

  // Driver: works through the step queue; register writes wait for a quiet block.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      drv_st <= DRV_NEXT;
      pend_head = 0;
      pend_cnt = 0;
      out_cnt = 0;
      seq_ctr = 16'd0;
      run_on = 1'b0;
      now_ms = 32'd0;
      tmo_reg = ptrt_pkg::TIMEOUT_RST;
      retry_reg = ptrt_pkg::RETRY_RST;
      par_reg = ptrt_pkg::PARALLEL_RST;
    end else begin
      case (drv_st)
        DRV_NEXT: begin
          if (step_q.size() > 0) begin
            cur = step_q.pop_front();
            if (cur.is_cfg) begin
              settle_cnt = 0;
              drv_st <= DRV_DRAIN;
            end else if (cur.gap == 0) begin
              item <= cur.cmd;
              start <= 1'b1;
              drv_st <= DRV_ISSUE;
            end else begin
              gap_cnt = cur.gap;
              drv_st <= DRV_GAP;
            end
          end
        end
        DRV_GAP: begin
          gap_cnt--;
          if (gap_cnt <= 0) begin
            item <= cur.cmd;
            start <= 1'b1;
            drv_st <= DRV_ISSUE;
          end
        end
        DRV_ISSUE: begin
          if (!busy) begin
            predict_events(cur.cmd);
            accepted_items++;
            start <= 1'b0;
            drv_st <= DRV_NEXT;
          end
        end
        DRV_DRAIN: begin
          // An enqueue leaves nothing to wait for, so also require a run of quiet cycles.
          if (probe_events_q.size() == 0 && !busy) settle_cnt++;
          else settle_cnt = 0;
          if (settle_cnt >= 30) begin
            psel <= 1'b1;
            pwrite <= 1'b1;
            paddr <= {cur.reg_idx, 2'b00};
            pwdata <= cur.value;
            drv_st <= DRV_SETUP;
          end
        end
        DRV_SETUP: begin
          penable <= 1'b1;
          drv_st <= DRV_ACCESS;
        end
        DRV_ACCESS: begin
          if (pready) begin
            // The register still shows its old value during the access cycle.
            if (prdata !== reg_value(cur.reg_idx)) begin
              cfg_errors++;
              if (cfg_errors <= 10)
                $display("register %0d read back: exp %0d got %0d",
                         cur.reg_idx, reg_value(cur.reg_idx), prdata);
            end
            apply_reg(cur.reg_idx, cur.value);
            cfg_writes++;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            drv_st <= DRV_NEXT;
          end
        end
        default: drv_st <= DRV_NEXT;
      endcase
    end
  end

  // Monitor: every strobed result is one transaction.
  always @(posedge clk) begin
    ptrt_pkg::result_t e;
    if (!rst && result_valid) begin
      if (probe_events_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected: kind=%0d tgt=%0d seq=%0d att=%0d lat=%0d last=%0d",
                   result.kind, result.probe_target, result.probe_sequence,
                   result.attempt, result.latency_ticks, result.last);
      end else begin
        e = probe_events_q.pop_front();
        checked_results++;
        if (e.kind !== result.kind || e.probe_target !== result.probe_target ||
            e.probe_sequence !== result.probe_sequence || e.attempt !== result.attempt ||
            e.latency_ticks !== result.latency_ticks || e.last !== result.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp kind=%0d tgt=%0d seq=%0d att=%0d lat=%0d last=%0d",
                     e.kind, e.probe_target, e.probe_sequence, e.attempt,
                     e.latency_ticks, e.last);
            $display("          got kind=%0d tgt=%0d seq=%0d att=%0d lat=%0d last=%0d",
                     result.kind, result.probe_target, result.probe_sequence,
                     result.attempt, result.latency_ticks, result.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 200000) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("probe_timeout_retry_tracker_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic add_cmd(logic [1:0] act, logic [9:0] t, logic [15:0] s);
    step_t st;
    st.is_cfg = 1'b0;
    st.reg_idx = '0;
    st.value = '0;
    st.gap = $urandom_range(0, 19);
    st.cmd.action = act;
    st.cmd.target = t;
    st.cmd.reply_sequence = s;
    step_q.push_back(st);
  endtask

  task automatic add_reg(logic [1:0] idx, logic [31:0] v);
    step_t st;
    st.is_cfg = 1'b1;
    st.reg_idx = idx;
    st.value = v;
    st.gap = 0;
    st.cmd = '0;
    step_q.push_back(st);
  endtask

  // One run: a few targets, a start, then mostly ticks and replies near live sequences.
  task automatic add_run(int n_tgt, int n_body, int seq_span);
    int r;
    for (int i = 0; i < n_tgt; i++)
      add_cmd(ptrt_pkg::ACT_ENQ, 10'($urandom), 16'($urandom));
    add_cmd(ptrt_pkg::ACT_START, 10'($urandom), 16'($urandom));
    for (int i = 0; i < n_body; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        add_cmd(ptrt_pkg::ACT_TICK, 10'($urandom), 16'($urandom));
      else if (r < 80)
        add_cmd(ptrt_pkg::ACT_REPLY, 10'($urandom), 16'($urandom_range(0, seq_span)));
      else if (r < 88)
        add_cmd(ptrt_pkg::ACT_ENQ, 10'($urandom), 16'($urandom));
      else if (r < 93)
        add_cmd(ptrt_pkg::ACT_START, 10'($urandom), 16'($urandom));
      else
        add_cmd(ptrt_pkg::ACT_REPLY, 10'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [31:0] tmo_set [10];
    logic [31:0] try_set [10];
    logic [31:0] par_set [10];
    int          leftover;

    // Directed: idle tick, unmatched reply, start with nothing queued, field extremes.
    add_cmd(ptrt_pkg::ACT_TICK, 10'd0, 16'd0);
    add_cmd(ptrt_pkg::ACT_REPLY, 10'd0, 16'hFFFF);
    add_cmd(ptrt_pkg::ACT_START, 10'h3FF, 16'hFFFF);
    add_reg(ptrt_pkg::REG_TIMEOUT, 32'd3);
    add_reg(ptrt_pkg::REG_RETRY, 32'd7);
    add_reg(ptrt_pkg::REG_PARALLEL, 32'd2);
    add_cmd(ptrt_pkg::ACT_ENQ, 10'd0, 16'hFFFF);
    add_cmd(ptrt_pkg::ACT_ENQ, 10'h3FF, 16'd0);
    add_cmd(ptrt_pkg::ACT_ENQ, 10'h2AA, 16'h5555);
    add_cmd(ptrt_pkg::ACT_START, 10'd0, 16'd0);
    add_cmd(ptrt_pkg::ACT_START, 10'd0, 16'd0);
    add_cmd(ptrt_pkg::ACT_ENQ, 10'h155, 16'hAAAA);
    add_cmd(ptrt_pkg::ACT_REPLY, 10'd0, 16'd1);
    add_cmd(ptrt_pkg::ACT_TICK, 10'd0, 16'd0);
    add_cmd(ptrt_pkg::ACT_TICK, 10'd0, 16'd0);
    add_cmd(ptrt_pkg::ACT_TICK, 10'd0, 16'd0);
    add_cmd(ptrt_pkg::ACT_REPLY, 10'd0, 16'd0);
    add_cmd(ptrt_pkg::ACT_REPLY, 10'h3FF, 16'd2);
    add_cmd(ptrt_pkg::ACT_REPLY, 10'd0, 16'd4);
    add_cmd(ptrt_pkg::ACT_REPLY, 10'd0, 16'd5);
    for (int i = 0; i < 12; i++) add_cmd(ptrt_pkg::ACT_TICK, 10'd0, 16'd0);

    // Zero and out-of-range register values, then settings that sweep the extremes.
    tmo_set = '{32'd0, 32'd1, 32'd2, 32'd4, 32'd65535, 32'd3, 32'd5000, 32'd1, 32'd6, 32'd2};
    try_set = '{32'd0, 32'd7, 32'd1, 32'd3, 32'd2, 32'd7, 32'd0, 32'd5, 32'd2, 32'd4};
    par_set = '{32'd0, 32'd8, 32'd1, 32'd15, 32'd3, 32'd9, 32'd8, 32'd4, 32'd6, 32'd2};
    for (int p = 0; p < 10; p++) begin
      add_reg(ptrt_pkg::REG_TIMEOUT, tmo_set[p]);
      add_reg(ptrt_pkg::REG_RETRY, try_set[p]);
      add_reg(ptrt_pkg::REG_PARALLEL, par_set[p]);
      for (int k = 0; k < 2; k++) add_run($urandom_range(1, 8), 10, 40);
      // Give runs with short timeouts a chance to finish before the next writes.
      if (tmo_set[p] < 100)
        for (int i = 0; i < 10; i++) add_cmd(ptrt_pkg::ACT_TICK, 10'd0, 16'd0);
    end

    // A longer queue drained with single-shot probes at full parallelism.
    add_reg(ptrt_pkg::REG_TIMEOUT, 32'd1);
    add_reg(ptrt_pkg::REG_RETRY, 32'd0);
    add_reg(ptrt_pkg::REG_PARALLEL, 32'd8);
    for (int i = 0; i < 30; i++)
      add_cmd(ptrt_pkg::ACT_ENQ, 10'($urandom), 16'($urandom));
    add_cmd(ptrt_pkg::ACT_START, 10'd0, 16'd0);
    for (int i = 0; i < 20; i++) add_cmd(ptrt_pkg::ACT_TICK, 10'd0, 16'd0);

    wait (!rst);
    do @(posedge clk);
    while (step_q.size() != 0 || drv_st != DRV_NEXT || busy ||
           probe_events_q.size() != 0);
    repeat (40) @(posedge clk);
    leftover = probe_events_q.size();

    $display("Ran %0d commands and %0d register writes; %0d results compared.",
             accepted_items, cfg_writes, checked_results);
    $display("%0d result mismatches, %0d read-back errors, %0d results never seen.",
             mismatches, cfg_errors, leftover);
    if (mismatches == 0 && cfg_errors == 0 && leftover == 0) begin
      $display("probe_timeout_retry_tracker_unit_tb OK");
    end else begin
      $display("probe_timeout_retry_tracker_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
